// File: hdl/bridge_concave_majorant_sup_defines.svh
// Assertion macros for the RTL of the bridge majorant block, used by bcm_engine.
// Each macro uses the clock clk and the active-low reset rst_n of the module.
`ifndef BRIDGE_CONCAVE_MAJORANT_SUP_DEFINES_SVH
`define BRIDGE_CONCAVE_MAJORANT_SUP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BCM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcm assertion failed");
// Next-cycle implication.
`define BCM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcm assertion failed");
`else
`define BCM_ASSERT_IMP(label, ante, cons)
`define BCM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hdl/bcm_pkg.sv
`default_nettype none
package bcm_pkg;

    // Width of the grid size register.
    localparam int CFG_W = 11;
    // Width of one result beat.
    localparam int OUT_W = 32;
    // Width of the running sum, Q24.24.
    localparam int SUM_W = 48;
    // Width of one stored bridge value, with headroom for the rounding term.
    localparam int BW = 50;

    localparam logic [CFG_W-1:0] PC_RESET = CFG_W'(1024);
    localparam logic [OUT_W-1:0] OUT_MAX  = '1;

    // Status from the engine to the channel logic.
    typedef struct packed {
        logic sample_ready;
        logic res_valid;
    } bcm_stat_t;

endpackage
`default_nettype wire

// File: hdl/bcm_inc_if.sv
`default_nettype none
interface bcm_inc_if #(
    parameter int SAMPLE_WIDTH = 32
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] increment;

    modport source (output valid, output increment, input ready);
    modport sink   (input valid, input increment, output ready);
endinterface
`default_nettype wire

// File: hdl/bcm_dev_if.sv
`default_nettype none
interface bcm_dev_if
    import bcm_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] max_deviation;

    modport source (output valid, output max_deviation, input ready);
    modport sink   (input valid, input max_deviation, output ready);
endinterface
`default_nettype wire

// File: hdl/bcm_div.sv
`default_nettype none
module bcm_div #(
    parameter int DW = 50,
    parameter int VW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int NW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [NW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          fit;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fit     = (shifted >= {1'b0, dvs_reg});
    end

    // Control: iteration count and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= NW'(DW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == NW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fit ? diff[VW-1:0] : shifted[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fit};
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: hdl/bcm_engine.sv
`default_nettype none
`include "bridge_concave_majorant_sup_defines.svh"
module bcm_engine
    import bcm_pkg::*;
#(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_W-1:0]               point_count,
    input  logic                           sample_beat,
    input  logic signed [SAMPLE_WIDTH-1:0] increment,
    input  logic                           res_ready,
    output bcm_stat_t                      stat,
    output logic [OUT_W-1:0]               res_data
);

    localparam int DEPTH = MAX_POINTS + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = IW + 1;
    localparam int CLW   = (IW > CFG_W) ? IW : CFG_W;
    localparam int GW    = BW + 2;
    localparam int PW    = BW + 1 + IW + 1;

    typedef enum logic [4:0] {
        S_COLLECT, S_WDIV, S_BRD, S_BWR,
        S_HRD, S_HPUSH, S_HCHK, S_HCMP, S_HZ1, S_HZ2,
        S_CSTK, S_CKNOT, S_CDY, S_CDIV, S_CRD, S_CEV,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          top_reg;
    logic [CW-1:0]          s_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                   wneg_reg;
    logic                   dyneg_reg;
    logic signed [GW-1:0]   acc_q_reg;
    logic [IW-1:0]          acc_r_reg;
    logic signed [GW-1:0]   step_q_reg;
    logic [IW-1:0]          step_r_reg;
    logic [IW-1:0]          zk_reg, xk_reg, yk_reg;
    logic signed [BW-1:0]   zb_reg, xb_reg, yb_reg;
    logic signed [PW-1:0]   lhs_reg, rhs_reg;
    logic [IW-1:0]          prev_k_reg;
    logic signed [BW-1:0]   prev_b_reg;
    logic [IW-1:0]          knot_reg;
    logic signed [BW-1:0]   b2_reg;
    logic [IW-1:0]          d_reg;
    logic [OUT_W-1:0]       best_reg;

    // Scratch memories: bridge values and hull knot indices.
    logic signed [BW-1:0]   bridge_mem [0:DEPTH-1];
    logic [IW-1:0]          stack_mem  [0:DEPTH-1];
    logic signed [BW-1:0]   brd_q;
    logic [IW-1:0]          srd_q;

    logic                   bw_en;
    logic [IW-1:0]          bw_addr;
    logic signed [BW-1:0]   bw_data;
    logic [IW-1:0]          br_addr;
    logic                   sw_en;
    logic [IW-1:0]          sw_addr;
    logic [IW-1:0]          sw_data;
    logic [IW-1:0]          sr_addr;

    logic                   div_start;
    logic [BW-1:0]          div_dividend;
    logic [IW-1:0]          div_divisor;
    logic                   div_busy;
    logic                   div_done;
    logic [BW-1:0]          div_quo;
    logic [IW-1:0]          div_rem;

    logic [CLW-1:0]         pc_ext;
    logic [IW-1:0]          n;
    logic signed [SUM_W-1:0] inc_ext;
    logic signed [SUM_W-1:0] new_sum;
    logic                   last_beat;
    logic [SUM_W-1:0]       wmag;

    logic [IW-1:0]          modv;
    logic [IW:0]            rsum;
    logic signed [GW-1:0]   q_stepped;
    logic [IW-1:0]          r_stepped;
    logic                   up_pos;
    logic                   up_neg;
    logic signed [GW-1:0]   rnd;
    logic signed [GW-1:0]   bval;

    logic signed [BW:0]     dl, dr;
    logic signed [IW:0]     kl, kr;
    logic [CW-1:0]          top_dec;

    logic signed [BW:0]     dy;
    logic [BW:0]            dymag;
    logic signed [GW-1:0]   qmag;
    logic signed [GW-1:0]   qd;
    logic [IW-1:0]          rd;

    logic signed [GW-1:0]   a_val;
    logic [GW-1:0]          amag;
    logic [GW-1:0]          gap;
    logic [OUT_W-1:0]       gap_sat;

    // Effective grid size: zero acts as one, large values clamp.
    always_comb
    begin
        pc_ext = CLW'(point_count);
        if (pc_ext == '0)
            n = IW'(1);
        else if (pc_ext > CLW'(MAX_POINTS))
            n = IW'(MAX_POINTS);
        else
            n = IW'(pc_ext);
    end

    // Running sum of the column.
    always_comb
    begin
        inc_ext   = SUM_W'(increment);
        new_sum   = sum_reg + inc_ext;
        last_beat = ((idx_reg + 1'b1) == CW'(n));
        wmag      = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
    end

    // Shared quotient/remainder stepper for i*w/n and k*dy/d.
    always_comb
    begin
        if (state_reg == S_BRD || state_reg == S_BWR)
            modv = n;
        else
            modv = d_reg;
        rsum = {1'b0, acc_r_reg} + {1'b0, step_r_reg};
        if (rsum >= {1'b0, modv})
        begin
            r_stepped = IW'(rsum - {1'b0, modv});
            q_stepped = acc_q_reg + step_q_reg + GW'(1);
        end
        else
        begin
            r_stepped = rsum[IW-1:0];
            q_stepped = acc_q_reg + step_q_reg;
        end
        up_pos = (({1'b0, acc_r_reg} + {1'b0, modv >> 1}) >= {1'b0, modv});
        up_neg = (({1'b0, modv - acc_r_reg} + {1'b0, modv >> 1}) >= {1'b0, modv});
    end

    // Bridge point: the raw sum less the rounded share of the end sum.
    always_comb
    begin
        rnd  = acc_q_reg + GW'(up_pos);
        bval = wneg_reg ? (GW'(brd_q) + rnd) : (GW'(brd_q) - rnd);
    end

    // Slope comparison by cross multiplication.
    always_comb
    begin
        dl      = (BW+1)'(xb_reg) - (BW+1)'(zb_reg);
        dr      = (BW+1)'(yb_reg) - (BW+1)'(xb_reg);
        kl      = $signed({1'b0, yk_reg - xk_reg});
        kr      = $signed({1'b0, xk_reg - zk_reg});
        top_dec = top_reg - 1'b1;
    end

    // Chord rise and its floor division by the span.
    always_comb
    begin
        dy    = (BW+1)'(brd_q) - (BW+1)'(prev_b_reg);
        dymag = dy[BW] ? (BW+1)'(-dy) : (BW+1)'(dy);
        qmag  = GW'(div_quo);
        if (!dyneg_reg)
        begin
            qd = qmag;
            rd = div_rem;
        end
        else if (div_rem == '0)
        begin
            qd = -qmag;
            rd = '0;
        end
        else
        begin
            qd = -qmag - GW'(1);
            rd = d_reg - div_rem;
        end
    end

    // Gap between chord and bridge, rounded half away from zero.
    always_comb
    begin
        a_val = GW'(prev_b_reg) - GW'(brd_q) + acc_q_reg;
        amag  = a_val[GW-1] ? GW'(-a_val) : GW'(a_val);
        if (!a_val[GW-1])
            gap = amag + GW'(up_pos);
        else if (acc_r_reg == '0)
            gap = amag;
        else
            gap = amag - GW'(1) + GW'(up_neg);
        gap_sat = (gap > GW'(OUT_MAX)) ? OUT_MAX : gap[OUT_W-1:0];
    end

    // Memory port and divider steering.
    always_comb
    begin
        bw_en        = 1'b0;
        bw_addr      = idx_reg[IW-1:0];
        bw_data      = BW'(new_sum);
        br_addr      = idx_reg[IW-1:0];
        sw_en        = 1'b0;
        sw_addr      = top_reg[IW-1:0];
        sw_data      = idx_reg[IW-1:0];
        sr_addr      = s_reg[IW-1:0];
        div_start    = 1'b0;
        div_dividend = BW'(wmag);
        div_divisor  = n;
        case (state_reg)
            S_COLLECT:
            begin
                if (sample_beat && !cfg_we)
                begin
                    bw_en   = 1'b1;
                    bw_addr = IW'(idx_reg + 1'b1);
                    div_start = last_beat;
                end
            end
            S_WDIV:
            begin
                bw_en   = div_done;
                bw_addr = '0;
                bw_data = '0;
            end
            S_BWR:
            begin
                bw_en   = 1'b1;
                bw_data = BW'(bval);
            end
            S_HPUSH:
            begin
                sw_en = 1'b1;
            end
            S_HCMP:
            begin
                sw_en   = (lhs_reg < rhs_reg);
                sw_addr = IW'(top_reg - CW'(2));
                sw_data = yk_reg;
                sr_addr = IW'(top_reg - CW'(4));
            end
            S_HZ1:
            begin
                br_addr = srd_q;
            end
            S_CKNOT:
            begin
                br_addr = srd_q;
            end
            S_CDY:
            begin
                div_start    = 1'b1;
                div_dividend = dymag[BW-1:0];
                div_divisor  = knot_reg - prev_k_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Bridge memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (bw_en)
            bridge_mem[bw_addr] <= bw_data;
        brd_q <= bridge_mem[br_addr];
    end

    // Hull stack memory.
    always_ff @(posedge clk)
    begin
        if (sw_en)
            stack_mem[sw_addr] <= sw_data;
        srd_q <= stack_mem[sr_addr];
    end

    bcm_div #(
        .DW (BW),
        .VW (IW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer: collect, bridge, hull, chord scan, deliver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            idx_reg   <= '0;
            top_reg   <= '0;
            s_reg     <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_COLLECT:
                begin
                    if (cfg_we)
                    begin
                        sum_reg <= '0;
                        idx_reg <= '0;
                    end
                    else if (sample_beat)
                    begin
                        if (last_beat)
                        begin
                            wneg_reg  <= new_sum[SUM_W-1];
                            sum_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_WDIV;
                        end
                        else
                        begin
                            sum_reg <= new_sum;
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        step_q_reg <= GW'(div_quo);
                        step_r_reg <= div_rem;
                        acc_q_reg  <= '0;
                        acc_r_reg  <= '0;
                        idx_reg    <= CW'(1);
                        state_reg  <= S_BRD;
                    end
                end
                S_BRD:
                begin
                    acc_q_reg <= q_stepped;
                    acc_r_reg <= r_stepped;
                    state_reg <= S_BWR;
                end
                S_BWR:
                begin
                    if (idx_reg == CW'(n))
                    begin
                        idx_reg   <= '0;
                        top_reg   <= '0;
                        state_reg <= S_HRD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_BRD;
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HPUSH;
                end
                S_HPUSH:
                begin
                    zk_reg    <= xk_reg;
                    zb_reg    <= xb_reg;
                    xk_reg    <= yk_reg;
                    xb_reg    <= yb_reg;
                    yk_reg    <= idx_reg[IW-1:0];
                    yb_reg    <= brd_q;
                    top_reg   <= top_reg + 1'b1;
                    state_reg <= S_HCHK;
                end
                S_HCHK:
                begin
                    if (top_reg >= CW'(3))
                    begin
                        lhs_reg   <= dl * kl;
                        rhs_reg   <= dr * kr;
                        state_reg <= S_HCMP;
                    end
                    else if (idx_reg == CW'(n))
                    begin
                        s_reg      <= CW'(1);
                        prev_k_reg <= '0;
                        prev_b_reg <= '0;
                        best_reg   <= '0;
                        state_reg  <= S_CSTK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_HRD;
                    end
                end
                S_HCMP:
                begin
                    if (lhs_reg < rhs_reg)
                    begin
                        // Drop the middle knot; refetch the one below it.
                        xk_reg  <= zk_reg;
                        xb_reg  <= zb_reg;
                        top_reg <= top_dec;
                        if (top_dec >= CW'(3))
                            state_reg <= S_HZ1;
                        else
                            state_reg <= S_HCHK;
                    end
                    else if (idx_reg == CW'(n))
                    begin
                        s_reg      <= CW'(1);
                        prev_k_reg <= '0;
                        prev_b_reg <= '0;
                        best_reg   <= '0;
                        state_reg  <= S_CSTK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_HRD;
                    end
                end
                S_HZ1:
                begin
                    zk_reg    <= srd_q;
                    state_reg <= S_HZ2;
                end
                S_HZ2:
                begin
                    zb_reg    <= brd_q;
                    state_reg <= S_HCHK;
                end
                S_CSTK:
                begin
                    state_reg <= S_CKNOT;
                end
                S_CKNOT:
                begin
                    knot_reg  <= srd_q;
                    state_reg <= S_CDY;
                end
                S_CDY:
                begin
                    b2_reg    <= brd_q;
                    dyneg_reg <= dy[BW];
                    d_reg     <= knot_reg - prev_k_reg;
                    state_reg <= S_CDIV;
                end
                S_CDIV:
                begin
                    if (div_done)
                    begin
                        acc_q_reg  <= qd;
                        acc_r_reg  <= rd;
                        step_q_reg <= qd;
                        step_r_reg <= rd;
                        idx_reg    <= CW'(prev_k_reg);
                        state_reg  <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    state_reg <= S_CEV;
                end
                S_CEV:
                begin
                    if (gap_sat > best_reg)
                        best_reg <= gap_sat;
                    acc_q_reg <= q_stepped;
                    acc_r_reg <= r_stepped;
                    if ((idx_reg + 1'b1) == CW'(knot_reg))
                    begin
                        prev_k_reg <= knot_reg;
                        prev_b_reg <= b2_reg;
                        s_reg      <= s_reg + 1'b1;
                        if ((s_reg + 1'b1) == top_reg)
                            state_reg <= S_DONE;
                        else
                            state_reg <= S_CSTK;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_CRD;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_COLLECT;
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    assign stat.sample_ready = (state_reg == S_COLLECT);
    assign stat.res_valid    = (state_reg == S_DONE);
    assign res_data          = best_reg;

    // The divider is never restarted while it is still iterating.
    `BCM_ASSERT_IMP(a_div_idle, div_start, !div_busy)
    // The hull never holds more knots than the n + 1 bridge points.
    `BCM_ASSERT_IMP(a_top_bound, state_reg == S_HCHK, top_reg <= ({1'b0, n} + 1'b1))
    // The chord scan stays strictly left of the right knot.
    `BCM_ASSERT_IMP(a_chord_span, state_reg == S_CEV, idx_reg < CW'(knot_reg))
    // A finished result waits until the output stage takes it.
    `BCM_ASSERT_NXT(a_res_hold, stat.res_valid && !res_ready, stat.res_valid)

endmodule
`default_nettype wire

// File: hdl/bridge_concave_majorant_sup.sv
// Sup distance between a discrete Brownian bridge and its least concave majorant.
// Channel sample carries one signed Q8.24 increment per beat; a column is
// point_count beats (zero acts as one, values above MAX_POINTS clamp).
// Channel result carries one unsigned Q8.24 max_deviation per column, saturated.
// Writing cfg_we/cfg_wdata sets point_count and drops any partial column.
// Samples are taken one per cycle while the block collects a column. After
// the last beat of a column the block stops taking samples and computes the
// end-sum division, the bridge, the hull, and a division and scan per hull
// chord; the one-read bridge memory port and the bit-serial divider pace
// these steps. The result then sits in an output register; the next column is
// collected while it waits. If the receiver still stalls when the next column
// is done, the engine holds that result and takes no samples until the
// register frees. Reset sets point_count to 1024 and starts an empty column;
// no clearing pass.
`default_nettype none
module bridge_concave_majorant_sup
    import bcm_pkg::*;
#(
    parameter int MAX_POINTS   = 1024,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    bcm_inc_if.sink          sample,
    bcm_dev_if.source        result
);

    logic [CFG_W-1:0] pc_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    bcm_stat_t        stat;
    logic [OUT_W-1:0] eng_data;
    logic             eng_res_ready;
    logic             sample_beat;

    // Grid size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_RESET;
        else if (cfg_we)
            pc_reg <= cfg_wdata;
    end

    assign sample.ready  = stat.sample_ready;
    assign sample_beat   = sample.valid && stat.sample_ready;
    assign eng_res_ready = !out_valid_reg || result.ready;

    bcm_engine #(
        .MAX_POINTS   (MAX_POINTS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .point_count (pc_reg),
        .sample_beat (sample_beat),
        .increment   (sample.increment),
        .res_ready   (eng_res_ready),
        .stat        (stat),
        .res_data    (eng_data)
    );

    // Output register between the engine and the result channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stat.res_valid && eng_res_ready)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stat.res_valid && eng_res_ready)
            out_data_reg <= eng_data;
    end

    assign result.valid         = out_valid_reg;
    assign result.max_deviation = out_data_reg;

endmodule
`default_nettype wire

// File: tb/bcm_tb_if.sv
`timescale 1ns / 1ps
// The RTL interfaces are reused as they stand; this file only keeps the
// checker's helper types apart from the block's package.
package bcm_tb_pkg;
    import bcm_pkg::*;
    localparam int TB_MAX_POINTS = 1024;
    typedef logic signed [SUM_W-1:0] sum_t;
endpackage

// File: tb/bcm_checker.sv
`timescale 1ns / 1ps
module bcm_checker
    import bcm_pkg::*;
    import bcm_tb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [31:0]      in_increment,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [OUT_W-1:0] out_dev,
    output int               fail_count,
    output int               pending
);
    logic [CFG_W-1:0] grid_reg;
    int               col_pos;
    sum_t             col_sum;
    longint           bridge_pts [0:TB_MAX_POINTS];
    logic [OUT_W-1:0] deviation_q [$];

    assign pending = deviation_q.size();

    // Magnitude of num over den, rounded to nearest with ties away from zero.
    function automatic longint round_mag(longint num, longint den);
        longint m;
        m = (num < 0) ? -num : num;
        return (m + den / 2) / den;
    endfunction

    // Sup gap between the bridge and its upper hull for one finished column.
    function automatic logic [OUT_W-1:0] column_gap(int n);
        longint wend, best, g, lhs, rhs, d, y1, dy, num;
        int     hull [0:TB_MAX_POINTS];
        int     top;
        wend = bridge_pts[n];
        bridge_pts[0] = 0;
        for (int i = 1; i <= n; i++)
        begin
            g = round_mag(longint'(i) * wend, n);
            bridge_pts[i] = bridge_pts[i] - ((i * wend < 0) ? -g : g);
        end
        top = 0;
        for (int i = 0; i <= n; i++)
        begin
            hull[top] = i;
            top++;
            while (top >= 3)
            begin
                lhs = (bridge_pts[hull[top-2]] - bridge_pts[hull[top-3]])
                      * (hull[top-1] - hull[top-2]);
                rhs = (bridge_pts[hull[top-1]] - bridge_pts[hull[top-2]])
                      * (hull[top-2] - hull[top-3]);
                if (lhs < rhs)
                begin
                    hull[top-2] = hull[top-1];
                    top--;
                end
                else
                    break;
            end
        end
        best = 0;
        for (int s = 1; s < top; s++)
        begin
            d  = hull[s] - hull[s-1];
            y1 = bridge_pts[hull[s-1]];
            dy = bridge_pts[hull[s]] - y1;
            for (int r = hull[s-1]; r < hull[s]; r++)
            begin
                num = y1 * d + dy * (r + 1 - hull[s-1]) - bridge_pts[r] * d;
                g = round_mag(num, d);
                if (g > 64'hFFFF_FFFF)
                    g = 64'hFFFF_FFFF;
                if (g > best)
                    best = g;
            end
        end
        return best[OUT_W-1:0];
    endfunction

    // Track configuration and samples, and compare each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            grid_reg   <= PC_RESET;
            col_pos    = 0;
            col_sum    = '0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                grid_reg <= cfg_wdata;
                col_pos  = 0;
                col_sum  = '0;
            end
            else if (in_valid && in_ready)
            begin
                n = (grid_reg == 0) ? 1 : (grid_reg > TB_MAX_POINTS) ? TB_MAX_POINTS
                    : int'(grid_reg);
                col_sum = col_sum + sum_t'($signed(in_increment));
                bridge_pts[col_pos + 1] = longint'(col_sum);
                col_pos++;
                if (col_pos >= n)
                begin
                    deviation_q.insert(deviation_q.size(), column_gap(n));
                    col_pos = 0;
                    col_sum = '0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (deviation_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, out_dev);
                    fail_count <= fail_count + 1;
                end
                else if (deviation_q[0] !== out_dev)
                begin
                    $display("%0t: max_deviation mismatch, expected %h, actual %h",
                             $time, deviation_q[0], out_dev);
                    fail_count <= fail_count + 1;
                    void'(deviation_q.pop_front());
                end
                else
                    void'(deviation_q.pop_front());
            end
        end
    end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import bcm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               cycle_count;
    logic             hold_off;
    logic             stall_on;

    bcm_inc_if #(.SAMPLE_WIDTH(32)) sample_ch ();
    bcm_dev_if                      result_ch ();

    bridge_concave_majorant_sup DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .sample   (sample_ch.sink),
        .result   (result_ch.source)
    );

    bcm_checker deviation_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (sample_ch.valid),
        .in_ready    (sample_ch.ready),
        .in_increment(sample_ch.increment),
        .out_valid   (result_ch.valid),
        .out_ready   (result_ch.ready),
        .out_dev     (result_ch.max_deviation),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: its own random stall pattern, plus a long hold-off on request.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                result_ch.ready <= 1'b0;
            else if (!stall_on)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Random increment with bias toward the field extremes.
    function automatic logic [31:0] pick_increment();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000) <<< 20;
            default: return $urandom();
        endcase
    endfunction

    // One beat on the sample channel, with a random gap first when bursting ends.
    task automatic send_sample(input logic [31:0] value, input bit gap);
        if (gap)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.increment <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Idle the channel, drain expectations and the compute tail, then write.
    task automatic set_grid(input logic [CFG_W-1:0] value);
        int guard;
        sample_ch.valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 400000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (12000) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_columns(input int items);
        int left;
        left = 0;
        for (int k = 0; k < items; k++)
        begin
            if (left == 0)
                left = $urandom_range(1, 20);
            send_sample(pick_increment(), (left == 1) && ($urandom_range(0, 1) == 1));
            left--;
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] grids [0:8];
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        hold_off            = 1'b0;
        stall_on            = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.increment = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: trivial grids, extreme values, and out-of-range sizes.
        set_grid(CFG_W'(0));
        send_sample(32'h7FFF_FFFF, 0);
        send_sample(32'h8000_0000, 0);
        set_grid(CFG_W'(2));
        send_sample(32'h0100_0000, 0);
        send_sample(32'hFF00_0000, 0);
        send_sample(32'h7FFF_FFFF, 0);
        send_sample(32'h7FFF_FFFF, 0);
        set_grid(CFG_W'(4));
        // A partial column is dropped by the next write.
        send_sample(32'h1234_5678, 0);
        send_sample(32'h8000_0000, 0);
        set_grid(CFG_W'(5));
        for (int k = 0; k < 10; k++)
            send_sample((k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 0);

        // Random columns on several small grids, with a stalling receiver.
        grids[0] = CFG_W'(1);  grids[1] = CFG_W'(3);  grids[2] = CFG_W'(7);
        grids[3] = CFG_W'(2);  grids[4] = CFG_W'(16); grids[5] = CFG_W'(5);
        grids[6] = CFG_W'(32); grids[7] = CFG_W'(9);  grids[8] = CFG_W'(1025);
        stall_on = 1'b1;
        for (int g = 0; g < 8; g++)
        begin
            set_grid(grids[g]);
            if (g == 2)
            begin
                // Long receiver hold-off while samples keep coming.
                hold_off = 1'b1;
                fork
                    begin
                        repeat (3000) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (g == 5)
                stall_on = 1'b0;
            if (g == 6)
                stall_on = 1'b1;
            send_columns(20);
        end
        // One full-size column on an oversized grid, which clamps.
        set_grid(grids[8]);
        send_columns(1024);

        sample_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
